// ===== rtl/core/kvte_pkg.sv =====
// Shared types and codes for the key-value table engine.
// Used by kvte_cell, key_value_table_engine_unit and the testbench files; depends on nothing else.
package kvte_pkg;

  localparam int KEY_BITS     = 32;
  localparam int PAY_MAX_BITS = 64;
  localparam int LIMIT_BITS   = 7;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_DEL = 2'd1,
    OP_UPD = 2'd2,
    OP_GET = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DUP  = 2'd2,
    ST_MISS = 2'd3
  } status_t;

  // Search word that travels from cell to cell, one cell per cycle.
  typedef struct packed {
    logic                    active;
    logic                    found;
    logic                    dup;
    logic [KEY_BITS-1:0]     key;
    logic [PAY_MAX_BITS-1:0] payload;
  } acc_t;

  // Operation broadcast to every cell while a word is being processed.
  typedef struct packed {
    logic                    start;
    logic                    commit_add;
    logic                    commit_upd;
    op_t                     op;
    logic [KEY_BITS-1:0]     skey;
    logic [KEY_BITS-1:0]     nkey;
    logic [PAY_MAX_BITS-1:0] npay;
  } cmd_t;

endpackage

// ===== rtl/core/kvte_cell.sv =====
// One table slot: holds a key and payload and passes the search word along.
// Depends on kvte_pkg.
module kvte_cell #(
  parameter int IDX          = 0,
  parameter int PAYLOAD_BITS = 64,
  parameter int CW           = 7
) (
  input  logic                              clk,
  input  logic                              rst,
  input  kvte_pkg::cmd_t                    cmd,
  input  logic [CW-1:0]                     count,
  input  kvte_pkg::acc_t                    acc_in,
  input  logic [kvte_pkg::KEY_BITS-1:0]     nxt_key,
  input  logic [PAYLOAD_BITS-1:0]           nxt_payload,
  output kvte_pkg::acc_t                    acc_out,
  output logic [kvte_pkg::KEY_BITS-1:0]     cell_key,
  output logic [PAYLOAD_BITS-1:0]           cell_payload
);
  import kvte_pkg::*;

  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;
  logic                    target;
  acc_t                    acc;
  acc_t                    acc_next;
  logic                    in_use;
  logic                    hit_s;
  logic                    hit_n;
  logic                    do_shift;

  assign in_use   = CW'(IDX) < count;
  assign hit_s    = acc_in.active && in_use && (cmd.op != OP_ADD) && (key == cmd.skey);
  assign hit_n    = acc_in.active && in_use && (key == cmd.nkey);
  // A delete pulls the neighbor's entry into every occupied slot from the match upward.
  assign do_shift = acc_in.active && in_use && (cmd.op == OP_DEL) &&
                    (acc_in.found || hit_s);

  always_comb begin
    acc_next        = acc_in;
    acc_next.found  = acc_in.found | hit_s;
    acc_next.dup    = acc_in.dup | (hit_n & ~hit_s);
    if (hit_s && cmd.op == OP_GET) begin
      acc_next.key     = key;
      acc_next.payload = PAY_MAX_BITS'(payload);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc.active <= 1'b0;
    end else begin
      acc.active <= acc_in.active;
    end
    acc.found   <= acc_next.found;
    acc.dup     <= acc_next.dup;
    acc.key     <= acc_next.key;
    acc.payload <= acc_next.payload;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target <= 1'b0;
    end else begin
      if (cmd.start) begin
        target <= 1'b0;
      end
      if (hit_s && cmd.op == OP_UPD) begin
        target <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_shift) begin
      key     <= nxt_key;
      payload <= nxt_payload;
    end else if ((cmd.commit_upd && target) ||
                 (cmd.commit_add && count == CW'(IDX))) begin
      key     <= cmd.nkey;
      payload <= cmd.npay[PAYLOAD_BITS-1:0];
    end
  end

  assign acc_out      = acc;
  assign cell_key     = key;
  assign cell_payload = payload;

endmodule

// ===== rtl/core/key_value_table_engine_unit.sv =====
// Key-value table engine: top level with the cell chain, entry count and handshakes.
// Depends on kvte_pkg and kvte_cell.
//
// A packed table of CAPACITY slots, each a 32-bit key with a PAYLOAD_BITS payload,
// serving add, delete, update and get. Each accepted word launches a search word
// that walks the chain of cells one slot per cycle; slots compare against it as it
// passes and a delete shifts entries down in the same walk. The search word's result is
// captured as it leaves the last cell and then registered at the output, so the delay
// grows with the length of the chain; the engine returns to idle as the result is
// presented and only then accepts the next word. One word is in work at a time, and
// the result sits in an output register so a new word can be taken while it waits.
// Configuration writes take effect at once and must be made while the table is idle.
module key_value_table_engine_unit #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [6:0]          cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          operation,
  input  logic signed [31:0]  search_key,
  input  logic signed [31:0]  new_key,
  input  logic [63:0]         new_payload,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [1:0]          status,
  output logic signed [31:0]  found_key,
  output logic [63:0]         found_payload
);
  import kvte_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int LW = (CW > LIMIT_BITS) ? CW : LIMIT_BITS;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                  state;
  logic [LIMIT_BITS-1:0]   limit;
  logic [CW-1:0]           count;
  logic                    start_q;
  op_t                     op;
  logic [KEY_BITS-1:0]     skey;
  logic [KEY_BITS-1:0]     nkey;
  logic [PAY_MAX_BITS-1:0] npay;
  logic                    res_found;
  logic                    res_dup;
  logic [KEY_BITS-1:0]     res_key;
  logic [PAY_MAX_BITS-1:0] res_payload;

  cmd_t                    cmd;
  acc_t                    acc_head;
  acc_t                    acc_chain [CAPACITY];
  logic [KEY_BITS-1:0]     key_chain [CAPACITY];
  logic [PAYLOAD_BITS-1:0] pay_chain [CAPACITY];

  logic                    accept;
  logic                    finish;
  logic [LW-1:0]           limit_w;
  logic [LW-1:0]           eff_limit;
  logic                    full;
  status_t                 st;
  logic                    get_ok;

  assign accept    = in_valid && in_ready;
  assign in_ready  = (state == S_IDLE);
  assign finish    = (state == S_FINISH) && (!out_valid || out_ready);
  assign limit_w   = LW'(limit);
  assign eff_limit = (limit_w > LW'(CAPACITY)) ? LW'(CAPACITY) : limit_w;
  assign full      = LW'(count) >= eff_limit;

  always_comb begin
    st = ST_OK;
    case (op)
      OP_ADD: begin
        if (full) begin
          st = ST_FULL;
        end else if (res_dup) begin
          st = ST_DUP;
        end
      end
      OP_UPD: begin
        if (!res_found) begin
          st = ST_MISS;
        end else if (res_dup) begin
          st = ST_DUP;
        end
      end
      OP_DEL, OP_GET: begin
        if (!res_found) begin
          st = ST_MISS;
        end
      end
      default: st = ST_OK;
    endcase
  end

  assign get_ok = (op == OP_GET) && res_found;

  always_comb begin
    cmd.start      = start_q;
    cmd.commit_add = finish && (op == OP_ADD) && (st == ST_OK);
    cmd.commit_upd = finish && (op == OP_UPD) && (st == ST_OK);
    cmd.op         = op;
    cmd.skey       = skey;
    cmd.nkey       = nkey;
    cmd.npay       = npay;
  end

  always_comb begin
    acc_head        = '0;
    acc_head.active = start_q;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    acc_t                    a_in;
    logic [KEY_BITS-1:0]     n_key;
    logic [PAYLOAD_BITS-1:0] n_pay;

    if (i == 0) begin : g_head
      assign a_in = acc_head;
    end else begin : g_link
      assign a_in = acc_chain[i-1];
    end

    // The top slot has no upper neighbor and reloads its own entry, which a delete leaves outside the count.
    if (i == CAPACITY - 1) begin : g_top
      assign n_key = key_chain[i];
      assign n_pay = pay_chain[i];
    end else begin : g_mid
      assign n_key = key_chain[i+1];
      assign n_pay = pay_chain[i+1];
    end

    kvte_cell #(
      .IDX          (i),
      .PAYLOAD_BITS (PAYLOAD_BITS),
      .CW           (CW)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .cmd          (cmd),
      .count        (count),
      .acc_in       (a_in),
      .nxt_key      (n_key),
      .nxt_payload  (n_pay),
      .acc_out      (acc_chain[i]),
      .cell_key     (key_chain[i]),
      .cell_payload (pay_chain[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      limit <= LIMIT_BITS'(64);
    end else if (cfg_we) begin
      limit <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      start_q   <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      start_q <= accept;
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (acc_chain[CAPACITY-1].active) begin
            state <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (finish) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            if (cmd.commit_add) begin
              count <= count + CW'(1);
            end else if (op == OP_DEL && st == ST_OK) begin
              count <= count - CW'(1);
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op   <= op_t'(operation);
      skey <= search_key;
      nkey <= new_key;
      npay <= new_payload;
    end
    if (state == S_SCAN && acc_chain[CAPACITY-1].active) begin
      res_found   <= acc_chain[CAPACITY-1].found;
      res_dup     <= acc_chain[CAPACITY-1].dup;
      res_key     <= acc_chain[CAPACITY-1].key;
      res_payload <= acc_chain[CAPACITY-1].payload;
    end
    if (finish) begin
      status        <= st;
      found_key     <= get_ok ? res_key : '0;
      found_payload <= get_ok ? res_payload : '0;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_start_follows_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> start_q)
    else $error("search word not launched after an accepted word");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_FINISH))
    else $error("result presented outside the finish step");

  a_count_changes_at_finish: assert property (@(posedge clk) disable iff (rst)
    !$stable(count) |-> $past(finish))
    else $error("entry count changed outside a commit");

  a_scan_end_in_scan: assert property (@(posedge clk) disable iff (rst)
    acc_chain[CAPACITY-1].active |-> (state == S_SCAN))
    else $error("search word left the chain outside a scan");

endmodule

// ===== test/kvte_table_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the key-value table engine: keeps its own copy of the table, predicts
// the reply to every accepted word and compares each reply the engine returns.
// Depends on kvte_pkg for the operation and status codes.
module kvte_table_checker #(
  parameter int CAPACITY     = 64,
  parameter int PAYLOAD_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic [1:0]         operation,
  input  logic signed [31:0] search_key,
  input  logic signed [31:0] new_key,
  input  logic [63:0]        new_payload,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         status,
  input  logic signed [31:0] found_key,
  input  logic [63:0]        found_payload,
  output int                 errors,
  output int                 pending
);
  import kvte_pkg::*;

  localparam logic [63:0] PAY_MASK = {64{1'b1}} >> (64 - PAYLOAD_BITS);
  localparam int          PRINT_CAP = 100;

  typedef struct packed {
    status_t     status;
    logic [31:0] key;
    logic [63:0] payload;
  } reply_t;

  logic [31:0] mirror_keys     [CAPACITY];
  logic [63:0] mirror_payloads [CAPACITY];
  int          mirror_count;
  logic [6:0]  limit_reg;
  reply_t      awaited_replies [$];
  int          reply_idx;

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < PRINT_CAP)
      $display("%0t reply %0d: %s is %h, predicted %h", $time, reply_idx, field, got, want);
    errors++;
  endtask

  // Lowest entry other than skip that holds key, or the count when there is none.
  function automatic int locate_key(input logic [31:0] key, input int skip);
    for (int i = 0; i < mirror_count; i++) begin
      if (i != skip && mirror_keys[i] == key)
        return i;
    end
    return mirror_count;
  endfunction

  function automatic reply_t apply_table_op(input op_t op, input logic [31:0] skey,
                                            input logic [31:0] nkey,
                                            input logic [63:0] npay);
    reply_t r;
    int     pos;
    int     lim;
    r.status  = ST_OK;
    r.key     = '0;
    r.payload = '0;
    lim  = (int'(limit_reg) > CAPACITY) ? CAPACITY : int'(limit_reg);
    npay = npay & PAY_MASK;
    if (op == OP_ADD) begin
      // A full table wins over a duplicate key.
      if (mirror_count >= lim) begin
        r.status = ST_FULL;
      end else if (locate_key(nkey, mirror_count) < mirror_count) begin
        r.status = ST_DUP;
      end else begin
        mirror_keys[mirror_count]     = nkey;
        mirror_payloads[mirror_count] = npay;
        mirror_count++;
      end
    end else begin
      pos = locate_key(skey, mirror_count);
      if (pos >= mirror_count) begin
        r.status = ST_MISS;
      end else if (op == OP_DEL) begin
        for (int i = pos; i + 1 < mirror_count; i++) begin
          mirror_keys[i]     = mirror_keys[i + 1];
          mirror_payloads[i] = mirror_payloads[i + 1];
        end
        mirror_count--;
      end else if (op == OP_UPD) begin
        // Keeping its own key is allowed; only other entries are duplicates.
        if (locate_key(nkey, pos) < mirror_count) begin
          r.status = ST_DUP;
        end else begin
          mirror_keys[pos]     = nkey;
          mirror_payloads[pos] = npay;
        end
      end else begin
        r.key     = mirror_keys[pos];
        r.payload = mirror_payloads[pos];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    reply_t want;
    if (rst) begin
      mirror_count = 0;
      limit_reg    = 7'd64;
      reply_idx    = 0;
      errors       = 0;
      awaited_replies.delete();
    end else begin
      if (cfg_we)
        limit_reg = cfg_wdata;
      if (in_valid && in_ready)
        awaited_replies.push_back(apply_table_op(op_t'(operation), search_key, new_key,
                                                 new_payload));
      if (out_valid && out_ready) begin
        if (awaited_replies.size() == 0) begin
          report_mismatch("unexpected reply", {62'd0, status}, 64'd0);
        end else begin
          want = awaited_replies.pop_front();
          if (status !== want.status)
            report_mismatch("status", {62'd0, status}, {62'd0, want.status});
          if (found_key !== want.key)
            report_mismatch("found_key", {32'd0, found_key}, {32'd0, want.key});
          if (found_payload !== want.payload)
            report_mismatch("found_payload", found_payload, want.payload);
        end
        reply_idx++;
      end
    end
    pending <= awaited_replies.size();
  end

endmodule

// ===== test/tb_key_value_table_engine_unit.sv =====
`timescale 1ns / 1ps
// Testbench top for key_value_table_engine_unit: clock, reset, stimulus and verdict.
// Depends on kvte_pkg, the engine RTL and the kvte_table_checker scoreboard.
module tb_key_value_table_engine_unit;
  import kvte_pkg::*;

  localparam int          CAPACITY     = 64;
  localparam int          PAYLOAD_BITS = 64;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          POOL_SIZE    = 96;
  localparam logic [31:0] KEY_MIN      = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX      = 32'h7fff_ffff;
  localparam logic [31:0] KEY_NEG1     = 32'hffff_ffff;

  logic               clk           = 1'b0;
  logic               rst           = 1'b1;
  logic               cfg_we        = 1'b0;
  logic [6:0]         cfg_wdata     = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [1:0]         operation     = '0;
  logic signed [31:0] search_key    = '0;
  logic signed [31:0] new_key       = '0;
  logic [63:0]        new_payload   = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [1:0]         status;
  logic signed [31:0] found_key;
  logic [63:0]        found_payload;
  int                 errors;
  int                 pending;
  int                 tx_idle_pct   = 35;
  int                 rx_idle_pct   = 78;
  logic               hold_req      = 1'b0;
  logic               hold_done     = 1'b0;
  int                 hold_left     = 0;
  int                 stall_cycles  = 0;
  logic [31:0]        key_pool [POOL_SIZE];

  key_value_table_engine_unit #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .search_key    (search_key),
    .new_key       (new_key),
    .new_payload   (new_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_key     (found_key),
    .found_payload (found_payload)
  );

  kvte_table_checker #(
    .CAPACITY     (CAPACITY),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) table_scoreboard (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .operation     (operation),
    .search_key    (search_key),
    .new_key       (new_key),
    .new_payload   (new_payload),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .found_key     (found_key),
    .found_payload (found_payload),
    .errors        (errors),
    .pending       (pending)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Reply side: random back-pressure, plus one long hold-off so the engine backs up.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= HOLD_CYCLES;
      out_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_key_value_table_engine_unit: errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic offer_word(input op_t op, input logic [31:0] skey, input logic [31:0] nkey,
                            input logic [63:0] pay);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    operation   <= op;
    search_key  <= skey;
    new_key     <= nkey;
    new_payload <= pay;
    in_valid    <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_engine();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_capacity_limit(input logic [6:0] lim);
    drain_engine();
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Mostly keys from a shared pool so lookups hit; a few fully random ones.
  function automatic logic [31:0] pick_key(input int span);
    if ($urandom_range(99) < 6)
      return $urandom;
    return key_pool[$urandom_range(span - 1)];
  endfunction

  function automatic logic [63:0] pick_payload();
    int roll;
    roll = $urandom_range(99);
    if (roll < 5)
      return '0;
    if (roll < 10)
      return '1;
    return {$urandom, $urandom};
  endfunction

  task automatic run_phase(input logic [6:0] lim, input int words, input int add_w,
                           input int del_w, input int upd_w, input int span,
                           input int tx, input int rx, input int hold_at);
    int  roll;
    op_t op;
    set_capacity_limit(lim);
    tx_idle_pct = tx;
    rx_idle_pct = rx;
    for (int n = 0; n < words; n++) begin
      if (n == hold_at)
        hold_req <= 1'b1;
      roll = $urandom_range(99);
      if (roll < add_w)
        op = OP_ADD;
      else if (roll < add_w + del_w)
        op = OP_DEL;
      else if (roll < add_w + del_w + upd_w)
        op = OP_UPD;
      else
        op = OP_GET;
      offer_word(op, pick_key(span), pick_key(span), pick_payload());
    end
  endtask

  initial begin
    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = 32'd0;
    key_pool[3] = KEY_NEG1;
    for (int i = 4; i < POOL_SIZE; i++)
      key_pool[i] = $urandom;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words on a three-entry table.
    set_capacity_limit(7'd3);
    offer_word(OP_ADD, 32'd0, KEY_MIN, 64'd0);
    offer_word(OP_ADD, 32'd0, KEY_MAX, {64{1'b1}});
    offer_word(OP_ADD, 32'd0, KEY_MIN, 64'd1);
    offer_word(OP_GET, KEY_MAX, 32'd0, 64'd0);
    offer_word(OP_GET, 32'd0, 32'd0, 64'd0);
    offer_word(OP_ADD, 32'd0, KEY_NEG1, 64'ha5a5_5a5a_f00d_c0de);
    offer_word(OP_ADD, 32'd0, 32'd5, 64'd5);
    // Full and duplicate at once must report full.
    offer_word(OP_ADD, 32'd0, KEY_MIN, 64'd7);
    offer_word(OP_UPD, KEY_MAX, KEY_MAX, 64'h8000_0000_0000_0001);
    offer_word(OP_UPD, KEY_NEG1, KEY_MIN, 64'd3);
    offer_word(OP_UPD, 32'd12, 32'd9, 64'd3);
    offer_word(OP_UPD, KEY_NEG1, 32'd0, 64'h0123_4567_89ab_cdef);
    offer_word(OP_GET, 32'd0, KEY_MAX, 64'd0);
    // Deleting the middle entry shifts the last one down.
    offer_word(OP_DEL, KEY_MAX, 32'd0, 64'd0);
    offer_word(OP_GET, 32'd0, 32'd0, 64'd0);
    offer_word(OP_DEL, 32'd12345, 32'd0, 64'd0);

    // Limit dropped below the current count: adds fail, the rest still works.
    set_capacity_limit(7'd1);
    offer_word(OP_ADD, 32'd0, 32'd7, 64'd7);
    offer_word(OP_GET, KEY_MIN, 32'd0, 64'd0);
    offer_word(OP_DEL, KEY_MIN, 32'd0, 64'd0);
    offer_word(OP_ADD, 32'd0, 32'd7, 64'd7);
    offer_word(OP_DEL, 32'd0, 32'd0, 64'd0);
    offer_word(OP_GET, 32'd0, 32'd0, 64'd0);
    offer_word(OP_DEL, 32'd0, 32'd0, 64'd0);
    set_capacity_limit(7'd0);
    offer_word(OP_ADD, 32'd0, KEY_MAX, 64'd1);
    offer_word(OP_GET, KEY_MAX, 32'd0, 64'd0);

    // Random phases; a limit of 127 acts as the built capacity.
    run_phase(7'd127, 300, 60, 10, 15, 96, 35, 78, -1);
    run_phase(7'd64,  300, 30, 30, 20, 96, 35, 78, 20);
    run_phase(7'd10,  250, 40, 25, 20, 24, 78, 35, -1);
    run_phase(7'd2,   250, 40, 25, 20, 6,  78, 35, -1);
    run_phase(7'd40,  300, 55, 10, 20, 64, 0,  0,  -1);
    run_phase(7'd5,   300, 25, 35, 20, 64, 0,  0,  -1);
    run_phase(7'd63,  50,  40, 20, 20, 32, 0,  0,  -1);

    drain_engine();
    repeat (CAPACITY + 10) @(posedge clk);
    if (errors == 0)
      $display("tb_key_value_table_engine_unit: clean");
    else
      $display("tb_key_value_table_engine_unit: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/kvte_pkg.sv
rtl/core/kvte_cell.sv
rtl/core/key_value_table_engine_unit.sv
test/kvte_table_checker.sv
test/tb_key_value_table_engine_unit.sv
